[rtl/core/edsr_pkg.sv]
// Shared types and constants for the DER-to-raw ECDSA signature converter.
package edsr_pkg;

    localparam int LEN_W    = 6;

    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] LONG_FORM    = 8'h80;
    localparam logic [7:0] COUNT_MASK   = 8'h7f;
    localparam logic [7:0] ZERO_BYTE    = 8'h00;
    localparam logic [2:0] MIN_BYTES    = 3'd6;

    typedef enum logic [2:0] {
        PH_SEQ_TAG   = 3'd0,
        PH_SEQ_LEN   = 3'd1,
        PH_LEN_MORE  = 3'd2,
        PH_INT_TAG   = 3'd3,
        PH_INT_LEN   = 3'd4,
        PH_INT_FIRST = 3'd5,
        PH_INT_VAL   = 3'd6,
        PH_DONE      = 3'd7
    } phase_t;

    typedef struct packed {
        logic             ok;
        logic             bank;
        logic [LEN_W-1:0] rlen;
        logic [LEN_W-1:0] slen;
    } job_t;

    typedef struct packed {
        logic en;
        logic bank;
    } bank_free_t;

endpackage

[rtl/core/edsr_front.sv]
// Front parser: checks the DER header and integers, writes value bytes, posts one job per signature.
module edsr_front
    import edsr_pkg::*;
#(
    parameter int HALF = 32,
    localparam int IW  = $clog2(2 * HALF)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // sig_byte
    input  logic          s_axis_tlast,   // final_byte
    input  logic          q_full,
    output logic          q_push,
    output job_t          q_job,
    input  bank_free_t    bank_free,
    output logic          mem_we,
    output logic [IW:0]   mem_waddr,
    output logic [7:0]    mem_wdata
);

    phase_t           phase_reg, phase_next;
    logic [15:0]      body_reg, body_next;
    logic [LEN_W-1:0] ilen_reg, ilen_next;
    logic             which_reg, which_next;
    logic             err_reg, err_next;
    logic [2:0]       pos_reg, pos_next;
    logic [LEN_W-1:0] rlen_reg, rlen_next;
    logic [LEN_W-1:0] slen_reg, slen_next;
    logic             wbank_reg, wbank_next;
    logic [1:0]       busy_reg, busy_next;

    logic             accept;
    logic             put;
    logic [LEN_W-1:0] ilen_dec;
    logic [IW:0]      base;
    logic             ok;
    logic [7:0]       b;

    assign b             = s_axis_tdata;
    assign s_axis_tready = !busy_reg[wbank_reg] && !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ilen_dec      = ilen_reg - LEN_W'(1);
    assign base          = which_reg ? (IW+1)'(2 * HALF) : (IW+1)'(HALF);

    always_comb
    begin
        phase_next = phase_reg;
        body_next  = body_reg;
        ilen_next  = ilen_reg;
        which_next = which_reg;
        err_next   = err_reg;
        rlen_next  = rlen_reg;
        slen_next  = slen_reg;
        pos_next   = (pos_reg == MIN_BYTES) ? pos_reg : pos_reg + 3'd1;
        put        = 1'b0;
        if (!err_reg)
        begin
            if ((phase_reg == PH_INT_TAG || phase_reg == PH_INT_LEN ||
                 phase_reg == PH_INT_FIRST || phase_reg == PH_INT_VAL ||
                 phase_reg == PH_DONE) && body_reg == 16'd0)
            begin
                err_next = 1'b1;
            end
            else
            begin
                if (phase_reg == PH_INT_TAG || phase_reg == PH_INT_LEN ||
                    phase_reg == PH_INT_FIRST || phase_reg == PH_INT_VAL ||
                    phase_reg == PH_DONE)
                begin
                    body_next = body_reg - 16'd1;
                end
                case (phase_reg)
                    PH_SEQ_TAG:
                    begin
                        if (b != TAG_SEQUENCE)
                            err_next = 1'b1;
                        else
                            phase_next = PH_SEQ_LEN;
                    end
                    PH_SEQ_LEN:
                    begin
                        if ((b & LONG_FORM) == ZERO_BYTE)
                        begin
                            body_next  = {8'd0, b};
                            phase_next = PH_INT_TAG;
                        end
                        else
                        begin
                            body_next = 16'd0;
                            if ((b & COUNT_MASK) > 8'd2)
                                err_next = 1'b1;
                            else if ((b & COUNT_MASK) == ZERO_BYTE)
                                phase_next = PH_INT_TAG;
                            else
                            begin
                                ilen_next  = LEN_W'(b & COUNT_MASK);
                                phase_next = PH_LEN_MORE;
                            end
                        end
                    end
                    PH_LEN_MORE:
                    begin
                        body_next = {body_reg[7:0], b};
                        ilen_next = ilen_dec;
                        if (ilen_dec == '0)
                            phase_next = PH_INT_TAG;
                    end
                    PH_INT_TAG:
                    begin
                        if (b != TAG_INTEGER)
                            err_next = 1'b1;
                        else
                            phase_next = PH_INT_LEN;
                    end
                    PH_INT_LEN:
                    begin
                        if (b == ZERO_BYTE || {1'b0, b} > 9'(HALF + 1))
                            err_next = 1'b1;
                        else
                        begin
                            ilen_next  = LEN_W'(b);
                            phase_next = PH_INT_FIRST;
                        end
                    end
                    PH_INT_FIRST:
                    begin
                        if (b == ZERO_BYTE)
                        begin
                            ilen_next = ilen_dec;
                            if (ilen_dec == '0)
                                err_next = 1'b1;
                            else
                            begin
                                phase_next = PH_INT_VAL;
                                if (which_reg)
                                    slen_next = ilen_dec;
                                else
                                    rlen_next = ilen_dec;
                            end
                        end
                        else if (b[7] || ilen_reg > LEN_W'(HALF))
                            err_next = 1'b1;
                        else
                        begin
                            put = 1'b1;
                            if (which_reg)
                                slen_next = ilen_reg;
                            else
                                rlen_next = ilen_reg;
                        end
                    end
                    PH_INT_VAL:
                        put = 1'b1;
                    default:
                        err_next = 1'b1;
                endcase
                if (put)
                begin
                    ilen_next = ilen_dec;
                    if (ilen_dec == '0)
                    begin
                        if (!which_reg)
                        begin
                            which_next = 1'b1;
                            phase_next = PH_INT_TAG;
                        end
                        else
                            phase_next = PH_DONE;
                    end
                end
            end
        end
    end

    assign ok = !err_next && phase_next == PH_DONE && body_next == 16'd0 &&
                pos_next == MIN_BYTES;

    assign mem_we    = accept && put;
    assign mem_waddr = {wbank_reg, IW'(base - (IW+1)'(ilen_reg))};
    assign mem_wdata = b;

    assign q_push     = accept && s_axis_tlast;
    assign q_job.ok   = ok;
    assign q_job.bank = wbank_reg;
    assign q_job.rlen = rlen_next;
    assign q_job.slen = slen_next;

    always_comb
    begin
        busy_next  = busy_reg;
        wbank_next = wbank_reg;
        if (bank_free.en)
            busy_next[bank_free.bank] = 1'b0;
        if (q_push && ok)
        begin
            busy_next[wbank_reg] = 1'b1;
            wbank_next           = !wbank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEQ_TAG;
            body_reg  <= '0;
            ilen_reg  <= '0;
            which_reg <= 1'b0;
            err_reg   <= 1'b0;
            pos_reg   <= '0;
            rlen_reg  <= '0;
            slen_reg  <= '0;
            wbank_reg <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            wbank_reg <= wbank_next;
            if (accept)
            begin
                if (s_axis_tlast)
                begin
                    phase_reg <= PH_SEQ_TAG;
                    body_reg  <= '0;
                    ilen_reg  <= '0;
                    which_reg <= 1'b0;
                    err_reg   <= 1'b0;
                    pos_reg   <= '0;
                    rlen_reg  <= '0;
                    slen_reg  <= '0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    body_reg  <= body_next;
                    ilen_reg  <= ilen_next;
                    which_reg <= which_next;
                    err_reg   <= err_next;
                    pos_reg   <= pos_next;
                    rlen_reg  <= rlen_next;
                    slen_reg  <= slen_next;
                end
            end
        end
    end

endmodule

[rtl/core/edsr_queue.sv]
// Two-entry job queue between parser and output sequencer.
module edsr_queue
    import edsr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head
);

    job_t       slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign head  = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? !wptr_reg : wptr_reg;
        rptr_next = pop ? !rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

[rtl/core/edsr_back.sv]
// Output sequencer: two-bank value store, registered read, output register.
module edsr_back
    import edsr_pkg::*;
#(
    parameter int HALF = 32,
    localparam int IW  = $clog2(2 * HALF)
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        mem_we,
    input  logic [IW:0] mem_waddr,
    input  logic [7:0]  mem_wdata,
    input  logic        q_empty,
    input  job_t        q_head,
    output logic        q_pop,
    output bank_free_t  bank_free,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // raw_byte
    output logic        m_axis_tuser,   // status
    output logic        m_axis_tlast    // end_of_run
);

    logic [7:0]  mem [2 ** (IW + 1)];
    logic [7:0]  mem_q_reg;

    logic [IW-1:0] k_reg, k_next;
    logic        rd_valid_reg, rd_valid_next;
    logic        rd_err_reg, rd_zero_reg, rd_last_reg;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg;
    logic        out_user_reg, out_last_reg;

    logic        out_load, rd_load, issue, k_last, zero;
    logic [IW:0] kx;

    assign out_load = rd_valid_reg && (!out_valid_reg || m_axis_tready);
    assign issue    = !q_empty && (!rd_valid_reg || out_load);
    assign rd_load  = issue && q_head.ok;
    assign k_last   = k_reg == IW'(2 * HALF - 1);
    assign kx       = {1'b0, k_reg};
    assign zero     = (kx < (IW+1)'(HALF)) ?
                      (kx < (IW+1)'(HALF) - (IW+1)'(q_head.rlen)) :
                      (kx < (IW+1)'(2 * HALF) - (IW+1)'(q_head.slen));

    assign q_pop          = issue && (!q_head.ok || k_last);
    assign bank_free.en   = issue && q_head.ok && k_last;
    assign bank_free.bank = q_head.bank;

    always_comb
    begin
        k_next = k_reg;
        if (rd_load)
            k_next = k_last ? '0 : k_reg + IW'(1);
        rd_valid_next = issue || (rd_valid_reg && !out_load);
        out_valid_next = out_load || (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_load)
            mem_q_reg <= mem[{q_head.bank, k_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_err_reg  <= !q_head.ok;
            rd_zero_reg <= !q_head.ok || zero;
            rd_last_reg <= !q_head.ok || k_last;
        end
        if (out_load)
        begin
            out_data_reg <= rd_zero_reg ? ZERO_BYTE : mem_q_reg;
            out_user_reg <= rd_err_reg;
            out_last_reg <= rd_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

[rtl/core/ecdsa_signature_der_to_raw.sv]
// Top level: DER ECDSA signature in, raw r||s bytes or one error result out.
//
//  channel  dir  tdata           tuser   tlast
//  s_axis   in   sig_byte[7:0]   -       final_byte
//  m_axis   out  raw_byte[7:0]   status  end_of_run
//
// Input takes one byte per cycle; the parser posts one job per signature into a
// two-entry queue. A good signature gives 2*HALF results, one per cycle while
// m_axis_tready holds, after its job passes the queue, the read register and
// the output register; a bad one gives one result. Input stalls while both store
// banks hold signatures not yet read out, or while two jobs wait in the queue.
// Reset is asynchronous and leaves the block ready for a new signature at once.
module ecdsa_signature_der_to_raw
    import edsr_pkg::*;
#(
    parameter int HALF = 32,
    localparam int IW  = $clog2(2 * HALF)
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // sig_byte
    input  logic       s_axis_tlast,   // final_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // raw_byte
    output logic       m_axis_tuser,   // status
    output logic       m_axis_tlast    // end_of_run
);

    logic        q_full, q_empty, q_push, q_pop;
    job_t        q_job, q_head;
    bank_free_t  bank_free;
    logic        mem_we;
    logic [IW:0] mem_waddr;
    logic [7:0]  mem_wdata;

    edsr_front #(.HALF(HALF)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (q_job),
        .bank_free     (bank_free),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata)
    );

    edsr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    edsr_back #(.HALF(HALF)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .bank_free     (bank_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[rtl/core/edsr_checker.sv]
// Port-level checker for the converter, bound to the top level.
module edsr_checker #(
    parameter int HALF = 32
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);

    logic       xfer;
    logic [6:0] run_cnt_reg, run_cnt_next;

    assign xfer = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        run_cnt_next = run_cnt_reg;
        if (xfer)
            run_cnt_next = m_axis_tlast ? 7'd0 : run_cnt_reg + 7'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_cnt_reg <= '0;
        else
            run_cnt_reg <= run_cnt_next;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
        $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'd0)
        else $error("error result malformed");

    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && run_cnt_reg != 7'd0 |-> !m_axis_tuser)
        else $error("error result inside a raw run");

    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && m_axis_tlast && !m_axis_tuser |-> run_cnt_reg == 7'(2 * HALF - 1))
        else $error("raw run of wrong length");

endmodule

bind ecdsa_signature_der_to_raw edsr_checker #(.HALF(HALF)) u_edsr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
